// ===== src/ttt_pkg.sv =====
// ----------------------------------------------------------------------------
// ttt_pkg: shared types and constants of the timeout timer table
// Sizes, operation and status codes, the command record passed from the
// front end to the executor, and the executor state encoding.
// ----------------------------------------------------------------------------
package ttt_pkg;

    localparam int CAPACITY    = 16;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int PTR_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    localparam int OP_W        = 3;
    localparam int TAG_W       = 32;
    localparam int DUR_W       = 32;
    localparam int IDX_W       = 4;
    localparam int STAT_W      = 2;
    localparam int LIVE_W      = 5;

    // common width for comparing an index against the fill count
    localparam int CMP_W       = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    localparam int CMDQ_DEPTH  = 2;
    localparam int CMDQ_PTR_W  = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CMDQ_FILL_W = $clog2(CMDQ_DEPTH + 1);

    typedef enum logic [OP_W-1:0] {
        OP_TICK      = 3'd0,
        OP_ADD       = 3'd1,
        OP_REMOVE    = 3'd2,
        OP_POLL      = 3'd3,
        OP_POLL_ALL  = 3'd4,
        OP_RESET     = 3'd5,
        OP_RESET_ALL = 3'd6,
        OP_CLEAR     = 3'd7
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK          = 2'd0,
        STAT_BAD_INDEX   = 2'd1,
        STAT_NOT_EXPIRED = 2'd2,
        STAT_FULL        = 2'd3
    } t_status;

    typedef struct packed {
        t_op              op;
        logic             multi;     // request may give several results
        logic [TAG_W-1:0] tag;
        logic [DUR_W-1:0] duration;
        logic [IDX_W-1:0] index;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_SCAN_END
    } t_state;

endpackage

// ===== src/ttt_front.sv =====
// ----------------------------------------------------------------------------
// ttt_front: request intake
// Accepts requests, decodes the operation and holds the classified command
// in one register until the command queue takes it.
// ----------------------------------------------------------------------------
module ttt_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [ttt_pkg::OP_W-1:0]  i_op,
    input  logic [ttt_pkg::TAG_W-1:0] i_tag,
    input  logic [ttt_pkg::DUR_W-1:0] i_duration,
    input  logic [ttt_pkg::IDX_W-1:0] i_index,
    output logic                      o_cmd_valid,
    input  logic                      i_cmd_ready,
    output ttt_pkg::t_cmd             o_cmd
);

    logic          r_valid;
    ttt_pkg::t_cmd r_cmd;
    ttt_pkg::t_cmd n_cmd;
    logic          accept;

    assign o_ready     = !r_valid || i_cmd_ready;
    assign accept      = i_valid && o_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    always_comb begin
        n_cmd.tag      = i_tag;
        n_cmd.duration = i_duration;
        n_cmd.index    = i_index;
        n_cmd.multi    = 1'b0;
        case (i_op)
            ttt_pkg::OP_TICK:      n_cmd.op = ttt_pkg::OP_TICK;
            ttt_pkg::OP_ADD:       n_cmd.op = ttt_pkg::OP_ADD;
            ttt_pkg::OP_REMOVE:    n_cmd.op = ttt_pkg::OP_REMOVE;
            ttt_pkg::OP_POLL:      n_cmd.op = ttt_pkg::OP_POLL;
            ttt_pkg::OP_POLL_ALL: begin
                n_cmd.op    = ttt_pkg::OP_POLL_ALL;
                n_cmd.multi = 1'b1;
            end
            ttt_pkg::OP_RESET:     n_cmd.op = ttt_pkg::OP_RESET;
            ttt_pkg::OP_RESET_ALL: n_cmd.op = ttt_pkg::OP_RESET_ALL;
            default:               n_cmd.op = ttt_pkg::OP_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_cmd_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// ===== src/ttt_cmdq.sv =====
// ----------------------------------------------------------------------------
// ttt_cmdq: command queue
// Short FIFO of classified commands between intake and executor.
// ----------------------------------------------------------------------------
module ttt_cmdq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  ttt_pkg::t_cmd i_push_cmd,
    output logic          o_pop_valid,
    input  logic          i_pop_ready,
    output ttt_pkg::t_cmd o_pop_cmd
);

    ttt_pkg::t_cmd                     r_mem [ttt_pkg::CMDQ_DEPTH];
    logic [ttt_pkg::CMDQ_PTR_W-1:0]    r_wr_ptr;
    logic [ttt_pkg::CMDQ_PTR_W-1:0]    r_rd_ptr;
    logic [ttt_pkg::CMDQ_FILL_W-1:0]   r_fill;
    logic                              push;
    logic                              pop;

    assign o_push_ready = r_fill != ttt_pkg::CMDQ_FILL_W'(ttt_pkg::CMDQ_DEPTH);
    assign o_pop_valid  = r_fill != '0;
    assign o_pop_cmd    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == ttt_pkg::CMDQ_PTR_W'(ttt_pkg::CMDQ_DEPTH - 1))
                            ? '0 : r_wr_ptr + ttt_pkg::CMDQ_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == ttt_pkg::CMDQ_PTR_W'(ttt_pkg::CMDQ_DEPTH - 1))
                            ? '0 : r_rd_ptr + ttt_pkg::CMDQ_PTR_W'(1);
            end
            if (push && !pop) begin
                r_fill <= r_fill + ttt_pkg::CMDQ_FILL_W'(1);
            end else if (pop && !push) begin
                r_fill <= r_fill - ttt_pkg::CMDQ_FILL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

// ===== src/ttt_back.sv =====
// ----------------------------------------------------------------------------
// ttt_back: timer table executor
// Holds the seconds count and the ordered timer entries, carries out one
// command at a time and drives the registered result port.
// ----------------------------------------------------------------------------
module ttt_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cmd_valid,
    output logic                       o_cmd_ready,
    input  ttt_pkg::t_cmd              i_cmd,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [ttt_pkg::STAT_W-1:0] o_status,
    output logic                       o_expired,
    output logic [ttt_pkg::TAG_W-1:0]  o_expired_tag,
    output logic [ttt_pkg::LIVE_W-1:0] o_live_count,
    output logic                       o_last
);

    localparam int CNT_W = ttt_pkg::CNT_W;
    localparam int PTR_W = ttt_pkg::PTR_W;
    localparam int CMP_W = ttt_pkg::CMP_W;

    // timer entries
    logic [ttt_pkg::TAG_W-1:0] r_ent_tag   [ttt_pkg::CAPACITY];
    logic [ttt_pkg::DUR_W-1:0] r_ent_start [ttt_pkg::CAPACITY];
    logic [ttt_pkg::DUR_W-1:0] r_ent_dur   [ttt_pkg::CAPACITY];

    ttt_pkg::t_state           r_state;
    ttt_pkg::t_state           n_state;
    ttt_pkg::t_cmd             r_cmd;
    logic [ttt_pkg::DUR_W-1:0] r_now;
    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          r_scan;

    logic [ttt_pkg::TAG_W-1:0] r_rd_tag;
    logic [ttt_pkg::DUR_W-1:0] r_rd_start;
    logic [ttt_pkg::DUR_W-1:0] r_rd_dur;

    logic                      r_have_pend;
    logic [ttt_pkg::TAG_W-1:0] r_pend_tag;
    logic [CNT_W-1:0]          r_pend_cnt;

    logic                      r_out_valid;
    ttt_pkg::t_status          r_out_status;
    logic                      r_out_exp;
    logic [ttt_pkg::TAG_W-1:0] r_out_tag;
    logic [CNT_W-1:0]          r_out_cnt;
    logic                      r_out_last;

    logic                      out_free;
    logic                      rd_expired;
    logic                      idx_ok;
    logic [CMP_W-1:0]          idx_ext;
    logic [PTR_W-1:0]          idx_ptr;
    logic                      scan_more;
    logic                      full;

    logic                      q_pop;
    logic                      rd_en;
    logic [PTR_W-1:0]          rd_addr;
    logic                      drop_en;
    logic [PTR_W-1:0]          drop_pos;
    logic                      app_en;
    logic                      rst_one_en;
    logic                      rst_all_en;
    logic                      clr_en;
    logic                      tick_en;
    logic                      pend_set;
    logic                      scan_inc;
    logic                      out_we;
    ttt_pkg::t_status          out_status;
    logic                      out_exp;
    logic [ttt_pkg::TAG_W-1:0] out_tag;
    logic [CNT_W-1:0]          out_cnt;
    logic                      out_last;

    assign out_free   = !r_out_valid || i_out_ready;
    assign rd_expired = {1'b0, r_now} > ({1'b0, r_rd_start} + {1'b0, r_rd_dur});
    assign idx_ext    = CMP_W'(r_cmd.index);
    assign idx_ptr    = idx_ext[PTR_W-1:0];
    assign idx_ok     = idx_ext < CMP_W'(r_count);
    assign scan_more  = r_scan < r_count;
    assign full       = r_count >= CNT_W'(ttt_pkg::CAPACITY);
    assign o_cmd_ready = q_pop;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ttt_pkg::ST_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = i_cmd.multi ? ttt_pkg::ST_SCAN_RD : ttt_pkg::ST_EXEC;
                end
            end
            ttt_pkg::ST_EXEC: begin
                if (out_free) begin
                    n_state = ttt_pkg::ST_IDLE;
                end
            end
            ttt_pkg::ST_SCAN_RD: begin
                n_state = scan_more ? ttt_pkg::ST_SCAN_CHK : ttt_pkg::ST_SCAN_END;
            end
            ttt_pkg::ST_SCAN_CHK: begin
                if (!rd_expired || !r_have_pend || out_free) begin
                    n_state = ttt_pkg::ST_SCAN_RD;
                end
            end
            ttt_pkg::ST_SCAN_END: begin
                if (out_free) begin
                    n_state = ttt_pkg::ST_IDLE;
                end
            end
            default: n_state = ttt_pkg::ST_IDLE;
        endcase
    end

    // datapath control
    always_comb begin
        q_pop      = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = idx_ptr;
        drop_en    = 1'b0;
        drop_pos   = idx_ptr;
        app_en     = 1'b0;
        rst_one_en = 1'b0;
        rst_all_en = 1'b0;
        clr_en     = 1'b0;
        tick_en    = 1'b0;
        pend_set   = 1'b0;
        scan_inc   = 1'b0;
        out_we     = 1'b0;
        out_status = ttt_pkg::STAT_OK;
        out_exp    = 1'b0;
        out_tag    = '0;
        out_cnt    = r_count;
        out_last   = 1'b1;
        case (r_state)
            ttt_pkg::ST_IDLE: begin
                if (i_cmd_valid) begin
                    q_pop   = 1'b1;
                    rd_en   = 1'b1;
                    rd_addr = PTR_W'(i_cmd.index);
                end
            end
            ttt_pkg::ST_EXEC: begin
                if (out_free) begin
                    out_we = 1'b1;
                    case (r_cmd.op)
                        ttt_pkg::OP_TICK: begin
                            tick_en = 1'b1;
                        end
                        ttt_pkg::OP_ADD: begin
                            if (full) begin
                                out_status = ttt_pkg::STAT_FULL;
                            end else begin
                                app_en  = 1'b1;
                                out_cnt = r_count + CNT_W'(1);
                            end
                        end
                        ttt_pkg::OP_REMOVE: begin
                            if (!idx_ok) begin
                                out_status = ttt_pkg::STAT_BAD_INDEX;
                            end else begin
                                drop_en = 1'b1;
                                out_cnt = r_count - CNT_W'(1);
                            end
                        end
                        ttt_pkg::OP_POLL: begin
                            if (!idx_ok) begin
                                out_status = ttt_pkg::STAT_BAD_INDEX;
                            end else if (!rd_expired) begin
                                out_status = ttt_pkg::STAT_NOT_EXPIRED;
                            end else begin
                                drop_en = 1'b1;
                                out_exp = 1'b1;
                                out_tag = r_rd_tag;
                                out_cnt = r_count - CNT_W'(1);
                            end
                        end
                        ttt_pkg::OP_RESET: begin
                            if (!idx_ok) begin
                                out_status = ttt_pkg::STAT_BAD_INDEX;
                            end else begin
                                rst_one_en = 1'b1;
                            end
                        end
                        ttt_pkg::OP_RESET_ALL: begin
                            rst_all_en = 1'b1;
                        end
                        ttt_pkg::OP_CLEAR: begin
                            clr_en  = 1'b1;
                            out_cnt = '0;
                        end
                        default: begin
                            out_status = ttt_pkg::STAT_OK;
                        end
                    endcase
                end
            end
            ttt_pkg::ST_SCAN_RD: begin
                rd_addr = r_scan[PTR_W-1:0];
                rd_en   = scan_more;
            end
            ttt_pkg::ST_SCAN_CHK: begin
                drop_pos = r_scan[PTR_W-1:0];
                if (!rd_expired) begin
                    scan_inc = 1'b1;
                end else if (!r_have_pend || out_free) begin
                    // release the previous hit, it is known not to be the last
                    out_we   = r_have_pend;
                    out_exp  = 1'b1;
                    out_tag  = r_pend_tag;
                    out_cnt  = r_pend_cnt;
                    out_last = 1'b0;
                    drop_en  = 1'b1;
                    pend_set = 1'b1;
                end
            end
            ttt_pkg::ST_SCAN_END: begin
                if (out_free) begin
                    out_we = 1'b1;
                    if (r_have_pend) begin
                        out_exp = 1'b1;
                        out_tag = r_pend_tag;
                        out_cnt = r_pend_cnt;
                    end
                end
            end
            default: begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ttt_pkg::ST_IDLE;
            r_now       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_have_pend <= 1'b0;
            r_scan      <= '0;
        end else begin
            r_state <= n_state;
            if (tick_en) begin
                r_now <= r_now + ttt_pkg::DUR_W'(1);
            end
            if (clr_en) begin
                r_count <= '0;
            end else if (app_en) begin
                r_count <= r_count + CNT_W'(1);
            end else if (drop_en) begin
                r_count <= r_count - CNT_W'(1);
            end
            if (q_pop) begin
                r_scan      <= '0;
                r_have_pend <= 1'b0;
            end else begin
                if (scan_inc) begin
                    r_scan <= r_scan + CNT_W'(1);
                end
                if (pend_set) begin
                    r_have_pend <= 1'b1;
                end
            end
            if (out_we) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_pop) begin
            r_cmd <= i_cmd;
        end
        if (rd_en) begin
            r_rd_tag   <= r_ent_tag[rd_addr];
            r_rd_start <= r_ent_start[rd_addr];
            r_rd_dur   <= r_ent_dur[rd_addr];
        end
        if (pend_set) begin
            r_pend_tag <= r_rd_tag;
            r_pend_cnt <= r_count - CNT_W'(1);
        end
        if (out_we) begin
            r_out_status <= out_status;
            r_out_exp    <= out_exp;
            r_out_tag    <= out_tag;
            r_out_cnt    <= out_cnt;
            r_out_last   <= out_last;
        end
    end

    // each entry either takes its successor (close a gap), is appended,
    // or restarts from the current time
    for (genvar j = 0; j < ttt_pkg::CAPACITY; j++) begin : g_ent
        localparam int SRC = (j < ttt_pkg::CAPACITY - 1) ? j + 1 : j;
        always_ff @(posedge i_clk) begin
            if (drop_en && (PTR_W'(j) >= drop_pos)) begin
                r_ent_tag[j]   <= r_ent_tag[SRC];
                r_ent_start[j] <= r_ent_start[SRC];
                r_ent_dur[j]   <= r_ent_dur[SRC];
            end else if (app_en && (r_count == CNT_W'(j))) begin
                r_ent_tag[j]   <= r_cmd.tag;
                r_ent_start[j] <= r_now;
                r_ent_dur[j]   <= r_cmd.duration;
            end else if (rst_all_en || (rst_one_en && (idx_ptr == PTR_W'(j)))) begin
                r_ent_start[j] <= r_now;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_expired     = r_out_exp;
    assign o_expired_tag = r_out_tag;
    assign o_live_count  = ttt_pkg::LIVE_W'(r_out_cnt);
    assign o_last        = r_out_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(ttt_pkg::CAPACITY))
        else $error("timer count above capacity");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !out_we)
        else $error("result overwritten while stalled");

    a_drop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        drop_en |-> (r_count != '0))
        else $error("entry dropped from an empty table");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ttt_pkg::ST_SCAN_CHK) |-> (r_scan < r_count))
        else $error("scan pointer past the live entries");

    a_append_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        app_en |-> !full)
        else $error("append into a full table");

endmodule

// ===== src/timeout_timer_table.sv =====
// ----------------------------------------------------------------------------
// timeout_timer_table: ordered table of one-shot timers
// Requests in on one valid/ready channel, results out on another. Request
// ops: tick, add, remove, poll, poll_all, reset, reset_all, clear. Every
// request gives one result with last set, except poll_all, which gives one
// result per expired timer (last on the final one) or a single "none expired".
//
// Requests pass an intake register and a two-entry command queue, then an
// executor that owns the seconds count and the timer entries.
// A request reaches its result through the intake register, the command
// queue, the executor's entry read and its result register. The executor
// takes no new request until it is through with the last: a single-result
// request is read from the table, then executed and its result written.
// Poll_all does one registered table read and one expiry compare per
// entry visited, up to CAPACITY; a removal closes the gap by shifting.
// Reset clears the seconds count, the table fill and all valid flags; the
// entry contents are left as they are. When the receiver holds ready low,
// the result register holds its result, the executor stops, and requests
// back up in the queue and intake register before o_in_ready drops.
// ----------------------------------------------------------------------------
module timeout_timer_table (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [ttt_pkg::OP_W-1:0]   i_op,
    input  logic [ttt_pkg::TAG_W-1:0]  i_tag,
    input  logic [ttt_pkg::DUR_W-1:0]  i_duration,
    input  logic [ttt_pkg::IDX_W-1:0]  i_index,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [ttt_pkg::STAT_W-1:0] o_status,
    output logic                       o_expired,
    output logic [ttt_pkg::TAG_W-1:0]  o_expired_tag,
    output logic [ttt_pkg::LIVE_W-1:0] o_live_count,
    output logic                       o_last
);

    // classified request from intake to queue
    ttt_pkg::t_cmd front_cmd;
    logic          front_valid;
    logic          q_push_ready;

    // queue head to executor
    ttt_pkg::t_cmd q_cmd;
    logic          q_valid;
    logic          back_ready;

    // decode the op and hold the request until the queue has room
    ttt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_op        (i_op),
        .i_tag       (i_tag),
        .i_duration  (i_duration),
        .i_index     (i_index),
        .o_cmd_valid (front_valid),
        .i_cmd_ready (q_push_ready),
        .o_cmd       (front_cmd)
    );

    // decouple intake from the executor so either side can stall alone
    ttt_cmdq u_cmdq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (q_push_ready),
        .i_push_cmd   (front_cmd),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (back_ready),
        .o_pop_cmd    (q_cmd)
    );

    // execute commands against the table and drive the result register
    ttt_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (q_valid),
        .o_cmd_ready   (back_ready),
        .i_cmd         (q_cmd),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_expired     (o_expired),
        .o_expired_tag (o_expired_tag),
        .o_live_count  (o_live_count),
        .o_last        (o_last)
    );

endmodule
